[sv/tcma_pkg.sv]
// Shared types and constants for the three-channel moving average unit.
// Depends on nothing; the other files that use it refer to it by scoped names.

package tcma_pkg;

    // Widths of the raw sample words and of the result fields.
    localparam int RAW_W    = 16;
    localparam int GAS_W    = 20;
    localparam int TEMP_W   = 15;
    localparam int HUM_W    = 14;
    localparam int USED_W   = 4;

    // Gas is reported in sixteenths, so its sum is shifted up before division.
    localparam int GAS_SHIFT = 4;
    // Temperature and humidity words have a full scale of 65536.
    localparam int SCALE_SHIFT = 16;
    localparam int MUL_W = 15;

    // Scale factors in hundredths of a degree and of a percent.
    localparam logic [MUL_W-1:0]         TEMP_MUL    = 15'd17500;
    localparam logic [MUL_W-1:0]         HUM_MUL     = 15'd10000;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = -15'sd4500;

    // One set of raw words, as held by one cell of the sample chain.
    typedef struct packed {
        logic [RAW_W-1:0] gas;
        logic [RAW_W-1:0] temp;
        logic [RAW_W-1:0] hum;
    } sample_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[sv/tcma_cell.sv]
// One cell of the sample chain: holds one set of raw words and passes it on.
// Depends on tcma_pkg for the sample type.

module tcma_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  tcma_pkg::sample_t sample_in,
    output tcma_pkg::sample_t sample_out
);

    tcma_pkg::sample_t sample_reg;

    // The cell takes its upstream neighbour's item whenever the chain shifts.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= sample_in;
        end
    end

    assign sample_out = sample_reg;

endmodule

[sv/tcma_div.sv]
// Restoring unsigned divider, one quotient bit per clock cycle.
// Stands alone; the top level instantiates one per channel.

module tcma_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVISOR_W:0]    partial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Control: count down one step per cycle after a start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: the dividend shifts out at the top as the quotient shifts in.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // One trial subtraction; the remainder always stays below the divisor.
    always_comb begin
        partial  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = partial - {1'b0, den_reg};
        fits     = (partial >= {1'b0, den_reg});
        rem_next = fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[sv/three_channel_moving_average_unit.sv]
// An accepted item passes through the scale, start, divide and done states of the sequencer,
// with the division done by the bit-serial dividers; no new item is accepted until its result
// is loaded, and DIV_W = 20 + clog2(WINDOW) is the width of the scaled gas sum.
// Reset (aresetn, synchronous, active low) clears the sums, fill count, sequencer
// and output valid; the sample chain is not cleared, as it is read only once full.
// Depends on tcma_pkg, tcma_cell and tcma_div.

module three_channel_moving_average_unit #(
    parameter int WINDOW = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tcma_pkg::RAW_W-1:0]          s_raw_gas,
    input  logic [tcma_pkg::RAW_W-1:0]          s_raw_temp,
    input  logic [tcma_pkg::RAW_W-1:0]          s_raw_hum,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tcma_pkg::GAS_W-1:0]          m_gas_mean,
    output logic signed [tcma_pkg::TEMP_W-1:0]  m_temp_mean,
    output logic [tcma_pkg::HUM_W-1:0]          m_hum_mean,
    output logic [tcma_pkg::USED_W-1:0]         m_samples_used
);

    localparam int SUM_W  = tcma_pkg::RAW_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DIV_W  = SUM_W + tcma_pkg::GAS_SHIFT;
    localparam int PROD_W = SUM_W + tcma_pkg::MUL_W;

    tcma_pkg::state_t  state_reg;
    tcma_pkg::state_t  state_next;
    tcma_pkg::sample_t cell_q [WINDOW];
    tcma_pkg::sample_t oldest;
    tcma_pkg::sample_t in_sample;

    logic              accept;
    logic              full;
    logic              div_start;
    logic              load_out;
    logic [2:0]        div_busy;
    logic [CNT_W-1:0]  fill_reg;
    logic [SUM_W-1:0]  gas_sum_reg;
    logic [SUM_W-1:0]  gas_sum_next;
    logic [SUM_W-1:0]  temp_sum_reg;
    logic [SUM_W-1:0]  temp_sum_next;
    logic [SUM_W-1:0]  hum_sum_reg;
    logic [SUM_W-1:0]  hum_sum_next;
    logic [PROD_W-1:0] temp_prod_reg;
    logic [PROD_W-1:0] hum_prod_reg;
    logic [DIV_W-1:0]  gas_dividend;
    logic [DIV_W-1:0]  temp_dividend;
    logic [DIV_W-1:0]  hum_dividend;
    logic [DIV_W-1:0]  gas_quo;
    logic [DIV_W-1:0]  temp_quo;
    logic [DIV_W-1:0]  hum_quo;

    logic                               m_valid_reg;
    logic [tcma_pkg::GAS_W-1:0]         gas_mean_reg;
    logic signed [tcma_pkg::TEMP_W-1:0] temp_mean_reg;
    logic [tcma_pkg::HUM_W-1:0]         hum_mean_reg;
    logic [tcma_pkg::USED_W-1:0]        used_reg;

    assign accept    = s_valid && s_ready;
    assign in_sample = '{gas: s_raw_gas, temp: s_raw_temp, hum: s_raw_hum};

    // Sample chain: the newest item enters cell 0, the oldest sits in the last cell.
    for (genvar i = 0; i < WINDOW; i++) begin : g_chain
        if (i == 0) begin : g_head
            tcma_cell u_cell (
                .aclk       (aclk),
                .shift_en   (accept),
                .sample_in  (in_sample),
                .sample_out (cell_q[i])
            );
        end else begin : g_body
            tcma_cell u_cell (
                .aclk       (aclk),
                .shift_en   (accept),
                .sample_in  (cell_q[i-1]),
                .sample_out (cell_q[i])
            );
        end
    end

    assign oldest = cell_q[WINDOW-1];
    assign full   = (fill_reg == CNT_W'(WINDOW));

    // Running sums: drop the item leaving the window once it is full, add the new one.
    always_comb begin
        gas_sum_next  = gas_sum_reg - (full ? SUM_W'(oldest.gas) : '0)
                        + SUM_W'(s_raw_gas);
        temp_sum_next = temp_sum_reg - (full ? SUM_W'(oldest.temp) : '0)
                        + SUM_W'(s_raw_temp);
        hum_sum_next  = hum_sum_reg - (full ? SUM_W'(oldest.hum) : '0)
                        + SUM_W'(s_raw_hum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            gas_sum_reg  <= '0;
            temp_sum_reg <= '0;
            hum_sum_reg  <= '0;
        end else if (accept) begin
            gas_sum_reg  <= gas_sum_next;
            temp_sum_reg <= temp_sum_next;
            hum_sum_reg  <= hum_sum_next;
            if (!full) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
        end
    end

    // Scale the temperature and humidity sums to hundredths before dividing.
    always_ff @(posedge aclk) begin
        if (state_reg == tcma_pkg::ST_SCALE) begin
            temp_prod_reg <= PROD_W'(temp_sum_reg) * PROD_W'(tcma_pkg::TEMP_MUL);
            hum_prod_reg  <= PROD_W'(hum_sum_reg) * PROD_W'(tcma_pkg::HUM_MUL);
        end
    end

    assign gas_dividend  = {gas_sum_reg, {tcma_pkg::GAS_SHIFT{1'b0}}};
    assign temp_dividend = DIV_W'(temp_prod_reg >> tcma_pkg::SCALE_SHIFT);
    assign hum_dividend  = DIV_W'(hum_prod_reg >> tcma_pkg::SCALE_SHIFT);

    // One divider per channel, all divided by the number of samples held.
    tcma_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(CNT_W)) u_div_gas (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (gas_dividend),
        .divisor  (fill_reg),
        .busy     (div_busy[0]),
        .quotient (gas_quo)
    );

    tcma_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(CNT_W)) u_div_temp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (temp_dividend),
        .divisor  (fill_reg),
        .busy     (div_busy[1]),
        .quotient (temp_quo)
    );

    tcma_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(CNT_W)) u_div_hum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (hum_dividend),
        .divisor  (fill_reg),
        .busy     (div_busy[2]),
        .quotient (hum_quo)
    );

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            tcma_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = tcma_pkg::ST_SCALE;
                end
            end
            tcma_pkg::ST_SCALE: begin
                state_next = tcma_pkg::ST_START;
            end
            tcma_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = tcma_pkg::ST_DIV;
            end
            tcma_pkg::ST_DIV: begin
                if (!div_busy[0]) begin
                    state_next = tcma_pkg::ST_DONE;
                end
            end
            tcma_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = tcma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcma_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: holds a result item until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            gas_mean_reg  <= gas_quo[tcma_pkg::GAS_W-1:0];
            temp_mean_reg <= $signed(temp_quo[tcma_pkg::TEMP_W-1:0])
                             + tcma_pkg::TEMP_OFFSET;
            hum_mean_reg  <= hum_quo[tcma_pkg::HUM_W-1:0];
            used_reg      <= tcma_pkg::USED_W'(fill_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_gas_mean     = gas_mean_reg;
    assign m_temp_mean    = temp_mean_reg;
    assign m_hum_mean     = hum_mean_reg;
    assign m_samples_used = used_reg;

`ifndef SYNTH
    // The fill count never passes the window length.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count above window length");

    // Each accepted item grows the fill count by one until the window is full.
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (fill_reg == $past(fill_reg) + CNT_W'(1)) || (fill_reg == CNT_W'(WINDOW)))
        else $error("fill count did not advance on an accepted item");

    // The three channel dividers run in lock step.
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_busy[0] == div_busy[1]) && (div_busy[0] == div_busy[2]))
        else $error("channel dividers out of step");

    // A delivered temperature never falls below the scale offset.
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temp_mean >= tcma_pkg::TEMP_OFFSET))
        else $error("temperature mean below range");
`endif

endmodule

[tb/sv/three_channel_moving_average_unit_tb.sv]
// Testbench for the three-channel moving average unit: random and directed sample sets,
// with every result checked against a predictor kept inside this file.
// Depends on tcma_pkg and three_channel_moving_average_unit.
`timescale 1ns / 1ps

module three_channel_moving_average_unit_tb;

    localparam int WINDOW_LEN   = 10;
    localparam int SLOT_W       = $clog2(WINDOW_LEN);
    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Result fields as the block presents them.
    typedef struct packed {
        logic [tcma_pkg::GAS_W-1:0]         gas;
        logic signed [tcma_pkg::TEMP_W-1:0] temp;
        logic [tcma_pkg::HUM_W-1:0]         hum;
        logic [tcma_pkg::USED_W-1:0]        used;
    } window_mean_t;

    // Receiver pacing styles.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_LONG,
        RX_SPARSE
    } rx_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [tcma_pkg::RAW_W-1:0] s_raw_gas  = '0;
    logic [tcma_pkg::RAW_W-1:0] s_raw_temp = '0;
    logic [tcma_pkg::RAW_W-1:0] s_raw_hum  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [tcma_pkg::GAS_W-1:0]         m_gas_mean;
    logic signed [tcma_pkg::TEMP_W-1:0] m_temp_mean;
    logic [tcma_pkg::HUM_W-1:0]         m_hum_mean;
    logic [tcma_pkg::USED_W-1:0]        m_samples_used;

    // Sample sets waiting to be sent and window means waiting to arrive.
    tcma_pkg::sample_t sample_backlog[$];
    window_mean_t      mean_backlog[$];

    // Predictor state: sample history, write position, fill level and sums.
    logic [tcma_pkg::RAW_W-1:0] gas_hist  [WINDOW_LEN];
    logic [tcma_pkg::RAW_W-1:0] temp_hist [WINDOW_LEN];
    logic [tcma_pkg::RAW_W-1:0] hum_hist  [WINDOW_LEN];
    logic [SLOT_W-1:0]          wr_slot   = '0;
    int unsigned                fill_cnt  = 0;
    logic [tcma_pkg::GAS_W-1:0] gas_total  = '0;
    logic [tcma_pkg::GAS_W-1:0] temp_total = '0;
    logic [tcma_pkg::GAS_W-1:0] hum_total  = '0;

    int       error_count = 0;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    int       gap_left    = 0;
    int       rx_tick     = 0;
    rx_mode_t rx_mode     = RX_ALWAYS;

    three_channel_moving_average_unit #(
        .WINDOW(WINDOW_LEN)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_gas      (s_raw_gas),
        .s_raw_temp     (s_raw_temp),
        .s_raw_hum      (s_raw_hum),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gas_mean     (m_gas_mean),
        .m_temp_mean    (m_temp_mean),
        .m_hum_mean     (m_hum_mean),
        .m_samples_used (m_samples_used)
    );

    always #2 aclk = ~aclk;

    // Pushes one sample set into the window and works out the resulting means.
    function automatic window_mean_t advance_window(input tcma_pkg::sample_t smp);
        window_mean_t      res;
        longint unsigned   n;
        longint unsigned   den;
        longint            temp_val;
        begin
            // Once full, the oldest sample leaves the sums before it is overwritten.
            if (fill_cnt >= WINDOW_LEN) begin
                gas_total  = gas_total  - tcma_pkg::GAS_W'(gas_hist[wr_slot]);
                temp_total = temp_total - tcma_pkg::GAS_W'(temp_hist[wr_slot]);
                hum_total  = hum_total  - tcma_pkg::GAS_W'(hum_hist[wr_slot]);
            end else begin
                fill_cnt = fill_cnt + 1;
            end
            gas_hist[wr_slot]  = smp.gas;
            temp_hist[wr_slot] = smp.temp;
            hum_hist[wr_slot]  = smp.hum;
            gas_total  = gas_total  + tcma_pkg::GAS_W'(smp.gas);
            temp_total = temp_total + tcma_pkg::GAS_W'(smp.temp);
            hum_total  = hum_total  + tcma_pkg::GAS_W'(smp.hum);
            wr_slot = (wr_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : wr_slot + SLOT_W'(1);

            n   = 64'(fill_cnt);
            den = 64'd65536 * n;
            temp_val = -64'sd4500 + longint'((64'(temp_total) * 64'd17500) / den);
            res.gas  = tcma_pkg::GAS_W'((64'(gas_total) * 64'd16) / n);
            res.temp = tcma_pkg::TEMP_W'(temp_val);
            res.hum  = tcma_pkg::HUM_W'((64'(hum_total) * 64'd10000) / den);
            res.used = tcma_pkg::USED_W'(n);
            return res;
        end
    endfunction

    function automatic void queue_sample(input logic [15:0] g, input logic [15:0] t,
                                         input logic [15:0] h);
        tcma_pkg::sample_t smp;
        begin
            smp.gas  = g;
            smp.temp = t;
            smp.hum  = h;
            sample_backlog.push_back(smp);
        end
    endfunction

    // Raw word biased towards the ends of the range and single-bit patterns.
    function automatic logic [15:0] pick_word();
        begin
            case ($urandom_range(0, 9))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return 16'h0001 << $urandom_range(0, 15);
                3: return ~(16'h0001 << $urandom_range(0, 15));
                default: return 16'($urandom);
            endcase
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin : feed_proc
        tcma_pkg::sample_t nxt;
        logic              nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt = {s_raw_gas, s_raw_temp, s_raw_hum};
            if (s_valid && s_ready) begin
                mean_backlog.push_back(advance_window(nxt));
            end
            if (!s_valid || s_ready) begin
                nxt_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                end else if (sample_backlog.size() != 0) begin
                    nxt       = sample_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end
                s_valid    <= nxt_valid;
                s_raw_gas  <= nxt.gas;
                s_raw_temp <= nxt.temp;
                s_raw_hum  <= nxt.hum;
            end
        end
    end

    // Receiver: the stall pattern periodically switches to a randomly chosen style.
    always @(posedge aclk) begin : rx_pace
        logic rdy;
        rx_tick = rx_tick + 1;
        if (rx_tick % 300 == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_ALWAYS: rdy = 1'b1;
            RX_COIN:   rdy = 1'($urandom_range(0, 1));
            RX_LONG:   rdy = (rx_tick % 37) >= 32;
            default:   rdy = ($urandom_range(0, 7) != 0);
        endcase
        m_ready <= rdy;
    end

    // Each accepted result is compared with the oldest outstanding prediction.
    always @(posedge aclk) begin : result_check
        window_mean_t exp_mean;
        if (aresetn && m_valid && m_ready) begin
            if (mean_backlog.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= 10) begin
                    $display("unexpected result: gas %0d temp %0d hum %0d used %0d",
                             m_gas_mean, m_temp_mean, m_hum_mean, m_samples_used);
                end
            end else begin
                exp_mean = mean_backlog.pop_front();
                if (exp_mean.gas !== m_gas_mean || exp_mean.temp !== m_temp_mean ||
                    exp_mean.hum !== m_hum_mean || exp_mean.used !== m_samples_used) begin
                    error_count = error_count + 1;
                    if (error_count <= 10) begin
                        $display("mismatch: expected gas %0d temp %0d hum %0d used %0d",
                                 exp_mean.gas, exp_mean.temp, exp_mean.hum, exp_mean.used);
                        $display("          got      gas %0d temp %0d hum %0d used %0d",
                                 m_gas_mean, m_temp_mean, m_hum_mean, m_samples_used);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin : stall_watch
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [15:0] g;
        logic [15:0] t;
        logic [15:0] h;
        int          run_len;
        int          i;
        int          k;

        // Warm-up at full scale, then a full window of maxima.
        for (i = 0; i < 12; i++) begin
            queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        end
        // Zeros replace the maxima one by one as the window slides.
        for (i = 0; i < 11; i++) begin
            queue_sample(16'h0000, 16'h0000, 16'h0000);
        end
        queue_sample(16'hFFFF, 16'h0000, 16'h8000);
        queue_sample(16'h0001, 16'hFFFF, 16'h7FFF);

        // Random part: mostly independent sets, with steady runs that settle the window.
        i = 0;
        while (i < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                g = pick_word();
                t = pick_word();
                h = pick_word();
                run_len = $urandom_range(WINDOW_LEN, 2 * WINDOW_LEN);
                for (k = 0; k < run_len; k++) begin
                    queue_sample(g, t, h);
                end
                i = i + run_len;
            end else begin
                queue_sample(pick_word(), pick_word(), pick_word());
                i = i + 1;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Let every item go out and every result come back.
        while (sample_backlog.size() != 0 || s_valid || mean_backlog.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && mean_backlog.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
